>>> src/cis_pkg.sv
// Shared types, constants and helpers for the cone isolation sums block.
package cis_pkg;

	localparam int FOOTPRINT_DEPTH_DEF = 16;

	localparam int NUM_SUMS   = 5;
	localparam int SUM_W      = 32;
	localparam int PT_W       = 16;
	localparam int INDEX_W    = 16;
	localparam int CONE_SQ_W  = 21;
	localparam int DELTA_W    = 15;
	localparam int DIST_SQ_W  = 30;

	localparam int SUM_CH_HADRON = 0;
	localparam int SUM_CHARGED   = 1;
	localparam int SUM_NEUTRAL   = 2;
	localparam int SUM_PHOTON    = 3;
	localparam int SUM_PILEUP    = 4;

	localparam logic signed [DELTA_W-1:0] PI_Q     = 15'sd3217;
	localparam logic signed [DELTA_W-1:0] TWO_PI_Q = 15'sd6434;
	localparam logic [PT_W-1:0]           PT_THRESHOLD = 16'd8;
	localparam logic [8:0]                ID_PHOTON   = 9'd22;
	localparam logic [8:0]                ID_ELECTRON = 9'd11;
	localparam logic [8:0]                ID_MUON     = 9'd13;
	localparam logic [1:0]                VERTEX_MIN  = 2'd2;
	localparam logic [CONE_SQ_W-1:0]      CONE_SQ_MAX = '1;

	typedef enum logic [1:0] {
		CMD_BEGIN     = 2'd0,
		CMD_FOOTPRINT = 2'd1,
		CMD_CANDIDATE = 2'd2
	} cmd_t;

	// Input payload, last field in the lowest bits
	typedef struct packed {
		logic [4:0]         pad;
		logic [1:0]         vertex_assoc;
		logic [8:0]         particle_id;
		logic signed [1:0]  charge;
		logic [PT_W-1:0]    pt;
		logic [INDEX_W-1:0] cand_index;
		logic [10:0]        cone_radius;
		logic signed [12:0] phi;
		logic signed [13:0] eta;
	} item_t;

	typedef struct packed {
		logic clear;
		logic add;
	} fp_ctrl_t;

	typedef struct packed {
		logic hit;
		logic overflow;
		logic full;
	} fp_status_t;

	function automatic logic signed [DELTA_W-1:0] wrap_phi(input logic signed [DELTA_W-1:0] d);
		logic signed [DELTA_W-1:0] v;
		v = d;
		for (int i = 0; i < 3; i++) begin
			if (v > PI_Q)
				v = v - TWO_PI_Q;
			else if (v < -PI_Q)
				v = v + TWO_PI_Q;
		end
		return v;
	endfunction

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [PT_W-1:0] b);
		logic [SUM_W:0] t;
		t = {1'b0, a} + {{(SUM_W + 1 - PT_W){1'b0}}, b};
		return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
	endfunction

endpackage

>>> src/cis_footprint.sv
// Footprint index store with parallel match against the candidate index.
module cis_footprint import cis_pkg::*; #(
	parameter int FOOTPRINT_DEPTH = FOOTPRINT_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fp_ctrl_t           ctrl,
	input  logic [INDEX_W-1:0] wr_index,
	input  logic [INDEX_W-1:0] lookup_index,
	output fp_status_t         status
);

	localparam int CW = $clog2(FOOTPRINT_DEPTH + 1);
	localparam int AW = (FOOTPRINT_DEPTH > 1) ? $clog2(FOOTPRINT_DEPTH) : 1;

	logic [INDEX_W-1:0]         store_q [FOOTPRINT_DEPTH];
	logic [CW-1:0]              count_q;
	logic                       overflow_q;
	logic                       full;
	logic [FOOTPRINT_DEPTH-1:0] match;

	assign full = (count_q == CW'(FOOTPRINT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (ctrl.clear) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (ctrl.add) begin
			if (full)
				overflow_q <= 1'b1;
			else
				count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.add && !ctrl.clear && !full)
			store_q[count_q[AW-1:0]] <= wr_index;
	end

	// only entries below the fill count take part
	for (genvar i = 0; i < FOOTPRINT_DEPTH; i++) begin : g_match
		assign match[i] = (count_q > CW'(i)) && (store_q[i] == lookup_index);
	end

	assign status.hit      = |match;
	assign status.overflow = overflow_q;
	assign status.full     = full;

endmodule

>>> src/cone_isolation_sums_unit.sv
// Top level: cone isolation sums over a stream of lepton, footprint and candidate requests.
//
// Input stream (s_*): one request per beat, kind in s_tuser (0 begin lepton, 1 footprint
// index, 2 candidate, 3 ignored), s_tlast asks for a result on begin and candidate requests.
// Output stream (m_*): one beat per result, the five pt sums in m_tdata and the footprint
// overflow flag in m_tuser.
// A request is registered in the input stage on acceptance and fully processed from there
// (distance, phi wrap, footprint compare and saturating add) into the result register,
// which drives m_tvalid. Throughput is one request per cycle while the input stage is not
// held; the single processing stage carries all state.
// Reset clears the lepton, the cone, the sums, the footprint count and overflow flag;
// footprint entries are only ever compared below the fill count.
// When the receiver stalls, the result register holds; requests without a result keep
// flowing, and the first one that needs the result register waits in the input stage,
// which then also holds s_tready low.
module cone_isolation_sums_unit import cis_pkg::*; #(
	parameter int FOOTPRINT_DEPTH = FOOTPRINT_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// eta[13:0] phi[26:14] cone_radius[37:27] cand_index[53:38] pt[69:54]
	// charge[71:70] particle_id[80:72] vertex_assoc[82:81] zero[87:83]
	input  logic [87:0]  s_tdata,
	// cmd[1:0]
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// charged_hadron_sum[31:0] charged_sum[63:32] neutral_sum[95:64]
	// photon_sum[127:96] pileup_sum[159:128]
	output logic [159:0] m_tdata,
	// footprint_overflow[0]
	output logic         m_tuser
);

	logic        valid_s1;
	item_t       item_s1;
	logic [1:0]  cmd_s1;
	logic        last_s1;

	logic signed [13:0]     lep_eta_q;
	logic signed [12:0]     lep_phi_q;
	logic [CONE_SQ_W-1:0]   cone_sq_q;
	logic [SUM_W-1:0]       sum_q [NUM_SUMS];
	logic [SUM_W-1:0]       sum_next [NUM_SUMS];
	logic [NUM_SUMS-1:0]    add_en;

	logic        is_begin, is_fp, is_cand, emit, proc;
	logic signed [DELTA_W-1:0] deta, dphi_raw, dphi;
	logic signed [DIST_SQ_W-1:0] eta_sq, phi_sq;
	logic [DIST_SQ_W-1:0] dist_sq;
	logic [21:0]          radius_sq;
	logic                 in_cone, take, neutral, from_vtx, above, is_lepton;

	fp_ctrl_t   fp_ctrl;
	fp_status_t fp_status;

	logic             out_valid_q;
	logic [159:0]     out_data_q;
	logic             out_flag_q;

	// input stage
	assign s_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_t'(s_tdata);
			cmd_s1  <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	always_comb begin
		is_begin = 1'b0;
		is_fp    = 1'b0;
		is_cand  = 1'b0;
		case (cmd_t'(cmd_s1))
			CMD_BEGIN:     is_begin = 1'b1;
			CMD_FOOTPRINT: is_fp    = 1'b1;
			CMD_CANDIDATE: is_cand  = 1'b1;
			default:       ;
		endcase
	end

	assign emit = last_s1 && (is_begin || is_cand);
	// hold only a request that needs the result register while it is still occupied
	assign proc = valid_s1 && !(emit && out_valid_q && !m_tready);

	// geometry
	assign deta     = {item_s1.eta[13], item_s1.eta} - {lep_eta_q[13], lep_eta_q};
	assign dphi_raw = {{2{item_s1.phi[12]}}, item_s1.phi} - {{2{lep_phi_q[12]}}, lep_phi_q};
	assign dphi     = wrap_phi(dphi_raw);
	assign eta_sq   = DIST_SQ_W'(deta) * DIST_SQ_W'(deta);
	assign phi_sq   = DIST_SQ_W'(dphi) * DIST_SQ_W'(dphi);
	assign dist_sq  = $unsigned(eta_sq) + $unsigned(phi_sq);
	assign in_cone  = dist_sq < {{(DIST_SQ_W - CONE_SQ_W){1'b0}}, cone_sq_q};
	assign radius_sq = 22'(item_s1.cone_radius) * 22'(item_s1.cone_radius);

	assign fp_ctrl.clear = proc && is_begin;
	assign fp_ctrl.add   = proc && is_fp;

	cis_footprint #(
		.FOOTPRINT_DEPTH(FOOTPRINT_DEPTH)
	) u_footprint (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (fp_ctrl),
		.wr_index    (item_s1.cand_index),
		.lookup_index(item_s1.cand_index),
		.status      (fp_status)
	);

	// classification
	assign take      = proc && is_cand && in_cone && !fp_status.hit;
	assign neutral   = (item_s1.charge == 2'sd0);
	assign from_vtx  = (item_s1.vertex_assoc >= VERTEX_MIN);
	assign above     = (item_s1.pt > PT_THRESHOLD);
	assign is_lepton = (item_s1.particle_id == ID_MUON) || (item_s1.particle_id == ID_ELECTRON);

	assign add_en[SUM_CH_HADRON] = take && !neutral && from_vtx && !is_lepton;
	assign add_en[SUM_CHARGED]   = take && !neutral && from_vtx;
	assign add_en[SUM_NEUTRAL]   = take && neutral && above
		&& (item_s1.particle_id != ID_PHOTON);
	assign add_en[SUM_PHOTON]    = take && neutral && above
		&& (item_s1.particle_id == ID_PHOTON);
	assign add_en[SUM_PILEUP]    = take && !neutral && !from_vtx && above;

	for (genvar k = 0; k < NUM_SUMS; k++) begin : g_sum
		always_comb begin
			if (is_begin)
				sum_next[k] = '0;
			else if (add_en[k])
				sum_next[k] = sat_add(sum_q[k], item_s1.pt);
			else
				sum_next[k] = sum_q[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sum_q[k] <= '0;
			else if (proc)
				sum_q[k] <= sum_next[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lep_eta_q <= '0;
			lep_phi_q <= '0;
			cone_sq_q <= '0;
		end else if (proc && is_begin) begin
			lep_eta_q <= item_s1.eta;
			lep_phi_q <= item_s1.phi;
			cone_sq_q <= radius_sq[21] ? CONE_SQ_MAX : radius_sq[CONE_SQ_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (proc && emit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			out_data_q <= {sum_next[SUM_PILEUP], sum_next[SUM_PHOTON], sum_next[SUM_NEUTRAL],
				sum_next[SUM_CHARGED], sum_next[SUM_CH_HADRON]};
			out_flag_q <= is_begin ? 1'b0 : fp_status.overflow;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_flag_q;

	// checks
	a_hadron_le_charged: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q[SUM_CH_HADRON] <= sum_q[SUM_CHARGED])
		else $error("charged hadron sum exceeds charged sum");

	a_begin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && is_begin |=> (sum_q[SUM_CHARGED] == '0) && (sum_q[SUM_NEUTRAL] == '0)
			&& (sum_q[SUM_PHOTON] == '0) && (sum_q[SUM_PILEUP] == '0) && !fp_status.overflow)
		else $error("sums not cleared after begin");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		fp_status.overflow |-> fp_status.full)
		else $error("footprint overflow without a full store");

	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !proc |-> emit && out_valid_q && !m_tready)
		else $error("input stage held without a pending result");

endmodule
